@@ rtl/clb_pkg.sv @@
// Shared constants and types for the comment and literal blanker.
`timescale 1ns / 1ps
package clb_pkg;

    // Character codes that steer both stages.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Default number of entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One queue entry: the one or two bytes that stage one made from an item.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       last;
    } t_pair;

endpackage

@@ rtl/clb_front.sv @@
// Front stage: accepts source bytes and blanks line and block comments.
`timescale 1ns / 1ps
module clb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    input  logic          i_queue_full,
    output logic          o_in_ready,
    output logic          o_push,
    output clb_pkg::t_pair o_pair
);
    import clb_pkg::*;

    typedef enum logic [2:0] {
        CM_NORMAL = 3'b001,
        CM_LINE   = 3'b010,
        CM_BLOCK  = 3'b100
    } t_cmode;

    t_cmode r_mode, n_mode;
    logic   r_slash_held, n_slash_held;
    logic   r_star_seen, n_star_seen;
    logic   emit;
    logic   accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_push     = accept && emit;

    // Classify the byte against the comment state and build the queue entry.
    always_comb begin
        n_mode         = r_mode;
        n_slash_held   = r_slash_held;
        n_star_seen    = r_star_seen;
        emit           = 1'b1;
        o_pair.byte0   = CH_SPACE;
        o_pair.byte1   = CH_SPACE;
        o_pair.two     = 1'b0;
        o_pair.last    = i_in_last;
        unique case (r_mode)
            CM_LINE: begin
                if (i_in_byte == CH_NL) begin
                    n_mode       = CM_NORMAL;
                    o_pair.byte0 = CH_NL;
                end
            end
            CM_BLOCK: begin
                if (r_star_seen && i_in_byte == CH_SLASH) begin
                    n_mode      = CM_NORMAL;
                    n_star_seen = 1'b0;
                end else begin
                    o_pair.byte0 = (i_in_byte == CH_NL) ? CH_NL : CH_SPACE;
                    n_star_seen  = (i_in_byte == CH_STAR);
                end
            end
            default: begin
                n_mode = CM_NORMAL;
                if (r_slash_held) begin
                    n_slash_held = 1'b0;
                    o_pair.two   = 1'b1;
                    if (i_in_byte == CH_SLASH) begin
                        n_mode = CM_LINE;
                    end else if (i_in_byte == CH_STAR) begin
                        n_mode      = CM_BLOCK;
                        n_star_seen = 1'b0;
                    end else begin
                        o_pair.byte0 = CH_SLASH;
                        o_pair.byte1 = i_in_byte;
                    end
                end else if (i_in_byte == CH_SLASH && !i_in_last) begin
                    // A slash waits for the next byte to tell what it opens.
                    n_slash_held = 1'b1;
                    emit         = 1'b0;
                end else begin
                    o_pair.byte0 = i_in_byte;
                end
            end
        endcase
        // The end of a text returns the stage to its starting state.
        if (i_in_last) begin
            n_mode       = CM_NORMAL;
            n_slash_held = 1'b0;
            n_star_seen  = 1'b0;
        end
    end

    // Comment state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= CM_NORMAL;
            r_slash_held <= 1'b0;
            r_star_seen  <= 1'b0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_slash_held <= n_slash_held;
            r_star_seen  <= n_star_seen;
        end
    end

    // A held slash only exists in normal text.
    a_held_in_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slash_held |-> r_mode == CM_NORMAL)
        else $error("slash held outside normal text");

    // A star inside a block comment is only tracked in block mode.
    a_star_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_star_seen |-> r_mode == CM_BLOCK)
        else $error("star flag set outside a block comment");

    // An item that ends a text always leaves at least one byte.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |-> o_push)
        else $error("final item produced no byte");

endmodule

@@ rtl/clb_queue.sv @@
// Short register queue of byte pairs between the front and back stages.
`timescale 1ns / 1ps
module clb_queue #(
    parameter int DEPTH = clb_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clb_pkg::t_pair i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output clb_pkg::t_pair o_data
);
    import clb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_pair         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Occupancy follows push and pop.
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue occupancy out of range");

endmodule

@@ rtl/clb_back.sv @@
// Back stage: blanks string and character literal contents, drives the output.
`timescale 1ns / 1ps
module clb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  clb_pkg::t_pair i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);
    import clb_pkg::*;

    typedef enum logic [4:0] {
        LM_OUT     = 5'b00001,
        LM_STR     = 5'b00010,
        LM_STR_ESC = 5'b00100,
        LM_CHR     = 5'b01000,
        LM_CHR_ESC = 5'b10000
    } t_lmode;

    t_lmode     r_lit, n_lit;
    logic       r_sub;
    logic       r_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last;
    logic [7:0] cur;
    logic       is_final;
    logic       step;

    assign cur      = r_sub ? i_q_data.byte1 : i_q_data.byte0;
    assign is_final = !i_q_data.two || r_sub;
    assign step     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop    = step && is_final;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    // Literal state machine on the current byte.
    always_comb begin
        n_lit      = r_lit;
        n_out_byte = CH_SPACE;
        unique case (r_lit)
            LM_STR: begin
                if (cur == CH_DQUOTE) begin
                    n_lit      = LM_OUT;
                    n_out_byte = cur;
                end else if (cur == CH_BSLASH) begin
                    n_lit = LM_STR_ESC;
                end else if (cur == CH_NL) begin
                    n_out_byte = CH_NL;
                end
            end
            LM_STR_ESC: n_lit = LM_STR;
            LM_CHR: begin
                if (cur == CH_SQUOTE) begin
                    n_lit      = LM_OUT;
                    n_out_byte = cur;
                end else if (cur == CH_BSLASH) begin
                    n_lit = LM_CHR_ESC;
                end
            end
            LM_CHR_ESC: n_lit = LM_CHR;
            default: begin
                n_out_byte = cur;
                if (cur == CH_DQUOTE) begin
                    n_lit = LM_STR;
                end else if (cur == CH_SQUOTE) begin
                    n_lit = LM_CHR;
                end else begin
                    n_lit = LM_OUT;
                end
            end
        endcase
        // The final byte of a text leaves the stage outside any literal.
        if (i_q_data.last && is_final) begin
            n_lit = LM_OUT;
        end
    end

    // Control state: literal mode, byte select within an entry, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit       <= LM_OUT;
            r_sub       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_lit       <= n_lit;
                r_sub       <= !is_final;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= n_out_byte;
            r_out_last <= i_q_data.last && is_final;
        end
    end

    a_sub_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (i_q_valid && i_q_data.two))
        else $error("second byte selected without a pending pair");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_q_data.last && is_final) |=> (r_lit == LM_OUT && !r_sub))
        else $error("state not cleared after final byte");

    a_pop_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_data.two) |-> r_sub)
        else $error("pair popped before its second byte");

endmodule

@@ rtl/comment_and_literal_blanker.sv @@
// Top level of the C comment and literal blanker.
//
// Input channel: i_in_valid / o_in_ready carry one source byte per item
// (i_in_byte) with i_in_last marking the final byte of a text. Output
// channel: o_out_valid / i_out_ready carry one cleaned byte per item
// (o_out_byte) with o_out_last on the final byte of the text.
// The front stage blanks comments and turns each input item into zero, one
// or two bytes; a queue of QUEUE_DEPTH entries holds them for the back stage,
// which blanks literal contents and fills the output register.
// A byte passes through the queue and then the output register; the second
// byte of a released slash pair follows the first, and a slash in normal
// text waits for the next item. Throughput: one input item per cycle while
// the queue is not full; the back stage drives one output byte per cycle
// while the receiver is ready, so an item that releases a held slash needs
// an output slot for each of its bytes and the queue absorbs the difference.
// Reset clears the queue, the output valid flag and all comment and literal
// state. When the receiver stalls the output byte holds, the queue fills,
// and o_in_ready drops once the queue is full.
`timescale 1ns / 1ps
module comment_and_literal_blanker #(
    parameter int QUEUE_DEPTH = clb_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import clb_pkg::*;

    logic  push, pop, q_full, q_valid;
    t_pair front_pair, q_pair;

    // Comment blanking and input handshake.
    clb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_queue_full (q_full),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_pair       (front_pair)
    );

    // Decoupling queue.
    clb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_pair),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_pair)
    );

    // Literal blanking and output register.
    clb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_pair),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

@@ tb/comment_and_literal_blanker_tb.sv @@
// Self-checking testbench for the comment and literal blanker with random C-like texts.
`timescale 1ns / 1ps
module comment_and_literal_blanker_tb;
    import clb_pkg::*;

    // Comment tracking and literal tracking states of the predictor.
    typedef enum logic [1:0] {CMT_NONE, CMT_LINE, CMT_BLOCK} t_cmt;
    typedef enum logic [2:0] {LIT_NONE, LIT_STR, LIT_STR_ESC, LIT_CHR, LIT_CHR_ESC} t_lit;

    // One source byte waiting to be sent, and one cleaned byte awaited.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } t_src;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_clean;

    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_TAIL   = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int PRINT_LIMIT  = 40;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    t_src   source_q[$];
    t_clean cleaned_q[$];

    // Predictor state.
    t_cmt       cmt_state;
    logic       slash_pending;
    logic       star_pending;
    t_lit       lit_state;

    int   errors;
    int   in_accepts;
    int   out_accepts;
    int   in_gap;
    int   out_gap;
    int   in_idle_pct;
    int   out_idle_pct;
    int   idle_cycles;
    logic quiet_tail;
    logic in_busy;
    t_src   next_src;
    t_clean want;

    comment_and_literal_blanker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    // Clock generation.
    always #5 i_clk = ~i_clk;

    // Literal stage: keeps quote marks, blanks literal contents.
    function automatic logic [7:0] blank_literal(input logic [7:0] c);
        logic [7:0] r;
        r = CH_SPACE;
        case (lit_state)
            LIT_STR: begin
                if (c == CH_DQUOTE) begin
                    lit_state = LIT_NONE;
                    r = c;
                end else if (c == CH_BSLASH) begin
                    lit_state = LIT_STR_ESC;
                end else if (c == CH_NL) begin
                    r = CH_NL;
                end
            end
            LIT_STR_ESC: lit_state = LIT_STR;
            LIT_CHR: begin
                if (c == CH_SQUOTE) begin
                    lit_state = LIT_NONE;
                    r = c;
                end else if (c == CH_BSLASH) begin
                    lit_state = LIT_CHR_ESC;
                end
            end
            LIT_CHR_ESC: lit_state = LIT_CHR;
            default: begin
                r = c;
                if (c == CH_DQUOTE) lit_state = LIT_STR;
                else if (c == CH_SQUOTE) lit_state = LIT_CHR;
                else lit_state = LIT_NONE;
            end
        endcase
        return r;
    endfunction

    // Clear all tracking state, as after reset or the end of a text.
    task automatic clear_tracking();
        cmt_state     = CMT_NONE;
        slash_pending = 1'b0;
        star_pending  = 1'b0;
        lit_state     = LIT_NONE;
    endtask

    // Work out the cleaned bytes that one accepted source byte produces.
    task automatic predict_cleaned(input logic [7:0] b, input logic last);
        logic [7:0] s1[2];
        int         n;
        t_clean     item;
        n = 0;
        if (cmt_state == CMT_LINE) begin
            if (b == CH_NL) begin
                cmt_state = CMT_NONE;
                s1[0] = CH_NL;
            end else begin
                s1[0] = CH_SPACE;
            end
            n = 1;
        end else if (cmt_state == CMT_BLOCK) begin
            if (star_pending && b == CH_SLASH) begin
                cmt_state = CMT_NONE;
                star_pending = 1'b0;
                s1[0] = CH_SPACE;
            end else begin
                s1[0] = (b == CH_NL) ? CH_NL : CH_SPACE;
                star_pending = (b == CH_STAR);
            end
            n = 1;
        end else if (slash_pending) begin
            slash_pending = 1'b0;
            if (b == CH_SLASH) begin
                cmt_state = CMT_LINE;
                s1[0] = CH_SPACE;
                s1[1] = CH_SPACE;
            end else if (b == CH_STAR) begin
                cmt_state = CMT_BLOCK;
                star_pending = 1'b0;
                s1[0] = CH_SPACE;
                s1[1] = CH_SPACE;
            end else begin
                s1[0] = CH_SLASH;
                s1[1] = b;
            end
            n = 2;
        end else if (b == CH_SLASH && !last) begin
            slash_pending = 1'b1;
        end else begin
            s1[0] = b;
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            item.data = blank_literal(s1[k]);
            item.last = last && (k == n - 1);
            cleaned_q.insert(cleaned_q.size(), item);
        end
        if (last) clear_tracking();
    endtask

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [7:0] got_b,
                                   input logic got_l, input logic [7:0] exp_b,
                                   input logic exp_l);
        if (errors < PRINT_LIMIT) begin
            $display("mismatch on output item %0d: %s: got %h last %b, expected %h last %b",
                     out_accepts, what, got_b, got_l, exp_b, exp_l);
        end
        errors++;
    endtask

    // Idle percentage for the next stretch, zero giving stretches without idling.
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 35;
            default: return 70;
        endcase
    endfunction

    // Append one source byte to the send queue.
    task automatic push_src(input logic [7:0] b);
        t_src s;
        s.data  = b;
        s.last  = 1'b0;
        s.drain = 1'b0;
        source_q.insert(source_q.size(), s);
    endtask

    // Append a string of source bytes, optionally closing the text.
    task automatic push_string(input string s, input logic close_text);
        for (int i = 0; i < s.len(); i++) push_src(s[i]);
        if (close_text) source_q[source_q.size() - 1].last = 1'b1;
    endtask

    // A byte for the inside of a comment or literal, biased toward the special ones.
    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 8))
            0: return 8'($urandom_range(0, 255));
            1: return CH_STAR;
            2: return CH_SLASH;
            3: return CH_NL;
            4: return CH_DQUOTE;
            5: return CH_SQUOTE;
            6: return CH_BSLASH;
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // One random text built from C-like pieces; some constructs are left unclosed.
    task automatic push_random_text();
        int pieces;
        pieces = $urandom_range(1, 12);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6)) push_src(8'h61 + 8'($urandom_range(0, 25)));
                1: begin
                    push_src(CH_SLASH);
                    push_src(CH_SLASH);
                    repeat ($urandom_range(0, 8)) push_src(body_byte());
                    if ($urandom_range(0, 7) != 0) push_src(CH_NL);
                end
                2: begin
                    push_src(CH_SLASH);
                    push_src(CH_STAR);
                    repeat ($urandom_range(0, 8)) push_src(body_byte());
                    if ($urandom_range(0, 7) != 0) begin
                        push_src(CH_STAR);
                        push_src(CH_SLASH);
                    end
                end
                3: begin
                    push_src(CH_DQUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 3) == 0) push_src(CH_BSLASH);
                        push_src(body_byte());
                    end
                    if ($urandom_range(0, 7) != 0) push_src(CH_DQUOTE);
                end
                4: begin
                    push_src(CH_SQUOTE);
                    if ($urandom_range(0, 1) == 0) push_src(CH_BSLASH);
                    push_src(body_byte());
                    if ($urandom_range(0, 7) != 0) push_src(CH_SQUOTE);
                end
                5: begin
                    push_src(CH_SLASH);
                    push_src(body_byte());
                end
                6: push_src(($urandom_range(0, 1) == 0) ? CH_NL : CH_SPACE);
                7: push_src(body_byte());
                default: push_src(8'($urandom_range(0, 255)));
            endcase
        end
        source_q[source_q.size() - 1].last = 1'b1;
    endtask

    // Input driver: presents queued source bytes with random idle bursts.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_busy = i_in_valid;
            quiet_tail = (source_q.size() < QUIET_TAIL);
            if (i_in_valid && o_in_ready) begin
                predict_cleaned(i_in_byte, i_in_last);
                in_accepts++;
                in_busy = 1'b0;
                if (in_accepts % 64 == 0) in_idle_pct = pick_idle_pct();
                if (!quiet_tail && $urandom_range(0, 99) < in_idle_pct) begin
                    in_gap = $urandom_range(1, 15);
                end
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (source_q.size() != 0 &&
                             !(source_q[0].drain && cleaned_q.size() != 0)) begin
                    next_src = source_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_byte  <= next_src.data;
                    i_in_last  <= next_src.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each cleaned byte and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (cleaned_q.size() == 0) begin
                    report_mismatch("unexpected item", o_out_byte, o_out_last, 8'h00, 1'b0);
                end else begin
                    want = cleaned_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        report_mismatch("byte", o_out_byte, o_out_last, want.data, want.last);
                    end
                    if (o_out_last !== want.last) begin
                        report_mismatch("last", o_out_byte, o_out_last, want.data, want.last);
                    end
                end
                out_accepts++;
                if (out_accepts % 64 == 0) out_idle_pct = pick_idle_pct();
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < out_idle_pct) begin
                out_gap = $urandom_range(0, 14);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus build, reset and end of run.
    initial begin
        int mid_mark;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_byte    = 8'h00;
        i_in_last    = 1'b0;
        i_out_ready  = 1'b0;
        errors       = 0;
        in_accepts   = 0;
        out_accepts  = 0;
        in_gap       = 0;
        out_gap      = 0;
        idle_cycles  = 0;
        quiet_tail   = 1'b0;
        in_idle_pct  = 20;
        out_idle_pct = 20;
        clear_tracking();

        // Directed texts: released slash, line comment, block comment whose
        // opening slash cannot close it, newline in a character literal,
        // escaped newline in a string, extreme byte values, trailing
        // backslash in a literal, slash as final byte, unclosed comment.
        push_string("/x", 1'b0);
        push_string("//a\n", 1'b0);
        push_string("/*/*/", 1'b0);
        push_string("'\n'", 1'b0);
        push_string("\"\\\n\"", 1'b0);
        push_src(8'h00);
        push_src(8'hFF);
        push_string("\"\\", 1'b1);
        push_string("/", 1'b1);
        push_string("/*", 1'b1);

        // Random texts; the sender drains the block before the first and
        // again before one in the middle of the run.
        mid_mark = 0;
        source_q[source_q.size() - 1].drain = 1'b0;
        while (source_q.size() < RANDOM_ITEMS + 25) begin
            if (mid_mark == 0 || (mid_mark == 1 && source_q.size() > RANDOM_ITEMS / 2)) begin
                push_random_text();
                mid_mark++;
            end else begin
                push_random_text();
            end
        end
        source_q[25].drain = 1'b1;
        for (int i = RANDOM_ITEMS / 2; i < source_q.size(); i++) begin
            if (source_q[i - 1].last) begin
                source_q[i].drain = 1'b1;
                break;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (source_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (cleaned_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (cleaned_q.size() != 0) begin
            report_mismatch("item never produced", 8'h00, 1'b0, cleaned_q[0].data,
                            cleaned_q[0].last);
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
